// ===== design/fldm_pkg.sv =====
package fldm_pkg;

   localparam int unsigned FRAME_PIXELS_W     = 21;
   localparam int unsigned WINDOW_FRAMES_W    = 7;
   localparam int unsigned PIXEL_W            = 8;
   localparam int unsigned FRAME_NUMBER_W     = 32;
   localparam int unsigned MOTION_W           = 39;
   localparam int unsigned WINDOW_W           = 45;

   localparam int unsigned MAX_FRAME_PIXELS_DEFAULT = 1048576;
   localparam int unsigned MAX_WINDOW_DEFAULT       = 64;

   localparam logic [FRAME_PIXELS_W-1:0]  FRAME_PIXELS_RESET  = FRAME_PIXELS_W'(307200);
   localparam logic [WINDOW_FRAMES_W-1:0] WINDOW_FRAMES_RESET = WINDOW_FRAMES_W'(1);

   localparam int unsigned CSR_INDEX_W = 1;
   localparam int unsigned CSR_DATA_W  = FRAME_PIXELS_W;
   localparam logic [CSR_INDEX_W-1:0] CSR_FRAME_PIXELS  = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_WINDOW_FRAMES = 1'b1;

   localparam int unsigned QUEUE_DEPTH = 8;
   localparam int unsigned QUEUE_AW    = 3;
   localparam int unsigned QUEUE_CW    = 4;

   localparam int unsigned PIPE_LATENCY = 6;

   localparam int unsigned LOG_FRACTION_BITS = 16;
   localparam int unsigned LOG_W             = LOG_FRACTION_BITS + 3;
   localparam int unsigned LOG_ENTRIES       = 256;
   localparam logic [63:0] LN2_Q64           = 64'hB17217F7D1CF79AB;

   typedef logic [LOG_ENTRIES-1:0][LOG_W-1:0] log_table_type;

   typedef struct packed {
      logic [FRAME_NUMBER_W-1:0] frame_number;
      logic [MOTION_W-1:0]       frame_motion;
      logic [WINDOW_W-1:0]       window_motion;
   } result_type;

   function automatic logic [LOG_W-1:0] fixed_ln(input int unsigned n);
      int unsigned  k;
      int           i;
      logic [63:0]  x;
      logic [63:0]  f;
      logic [63:0]  l2;
      logic [63:0]  hi;
      logic [127:0] prod;
      k = 0;
      while (k < 8 && (n >> (k + 1)) != 0) begin
         k = k + 1;
      end
      x = 64'(n) << (62 - k);
      f = '0;
      for (i = 59; i >= 0; i--) begin
         prod = {64'd0, x} * {64'd0, x};
         x = prod[125:62];
         if (x[63]) begin
            f[i] = 1'b1;
            x = x >> 1;
         end
      end
      l2 = (64'(k) << 60) | f;
      prod = {64'd0, l2} * {64'd0, LN2_Q64};
      hi = prod[127:64];
      return LOG_W'((hi + (64'd1 << (59 - LOG_FRACTION_BITS))) >> (60 - LOG_FRACTION_BITS));
   endfunction

   function automatic log_table_type build_log_table();
      log_table_type t;
      int unsigned   i;
      for (i = 0; i < LOG_ENTRIES; i++) begin
         t[i] = fixed_ln(i + 1);
      end
      return t;
   endfunction

   localparam log_table_type LOG_TABLE = build_log_table();

endpackage

// ===== design/fldm_ram.sv =====
module fldm_ram #(
   parameter int unsigned WIDTH  = 8,
   parameter int unsigned DEPTH  = 256,
   parameter int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

// ===== design/frame_log_difference_motion.sv =====
// Frame-difference motion meter. Takes one 8-bit grey pixel per clock in raster order while
// req_stall is low and, after the last pixel of each frame, returns the frame number, the sum
// over the frame of |ln(new+1) - ln(old+1)| against the previous frame (16 fraction bits) and
// the sum of that value over the last window_frames frames. Throughput is one pixel per cycle
// while req_stall is low; the previous frame sits in a single-port-write, single-port-read memory
// of MAX_FRAME_PIXELS bytes that is read and written at the same address in the accept cycle, and
// a fill count stands in for clearing it, so there is no clearing pass after reset and frame 0 is
// measured against black. The window sum comes from a ring memory of MAX_WINDOW running totals.
// rsp_valid rises once the last pixel of a frame has passed stages 1 to 5 and its result sits in
// the output queue; up to 8 results are held in that queue, and req_stall rises only when the
// queued results plus the requests still in the 5-stage pipeline reach 8. Write csr_ registers
// only while the block is idle; frame_pixels of 0 acts as 1 and values above the maximum clamp.
module frame_log_difference_motion
   import fldm_pkg::*;
#(
   parameter int unsigned MAX_FRAME_PIXELS = MAX_FRAME_PIXELS_DEFAULT,
   parameter int unsigned MAX_WINDOW       = MAX_WINDOW_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_write,
   input  logic [CSR_INDEX_W-1:0]    csr_index,
   input  logic [CSR_DATA_W-1:0]     csr_data,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic [PIXEL_W-1:0]        req_pixel,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [FRAME_NUMBER_W-1:0] rsp_frame_number,
   output logic [MOTION_W-1:0]       rsp_frame_motion,
   output logic [WINDOW_W-1:0]       rsp_window_motion
);

   localparam int unsigned PIX_AW  = (MAX_FRAME_PIXELS > 1) ? $clog2(MAX_FRAME_PIXELS) : 1;
   localparam int unsigned SCW     = (PIX_AW + 1 > FRAME_PIXELS_W) ? PIX_AW + 1 : FRAME_PIXELS_W;
   localparam int unsigned RING_AW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
   localparam int unsigned WCW     = ($clog2(MAX_WINDOW + 1) > WINDOW_FRAMES_W) ?
                                     $clog2(MAX_WINDOW + 1) : WINDOW_FRAMES_W;

   // configuration
   logic [FRAME_PIXELS_W-1:0]  frame_pixels_ff, frame_pixels_in;
   logic [WINDOW_FRAMES_W-1:0] window_frames_ff, window_frames_in;
   logic [SCW-1:0]             size_eff;
   logic [WCW-1:0]             win_eff;

   // accept stage
   logic                       req_accept;
   logic                       frame_end0;
   logic [PIX_AW-1:0]          pos_ff, pos_in;
   logic [PIX_AW:0]            fill_ff, fill_in;
   logic [PIXEL_W-1:0]         prev_q;

   // stage 1
   logic                       v1_ff, end1_ff, ok1_ff;
   logic [PIXEL_W-1:0]         pix1_ff;

   // stage 2
   logic                       v2_ff, end2_ff;
   logic [LOG_W-1:0]           a2_ff, b2_ff;

   // stage 3
   logic                       v3_ff, end3_ff;
   logic [LOG_W-1:0]           diff3_ff;
   logic [MOTION_W-1:0]        acc_ff, acc_in, acc_sum;

   // stage 4
   logic                       v4_ff;
   logic [MOTION_W-1:0]        motion4_ff;
   logic [WINDOW_W-1:0]        cum_ff, cum_in, cum_new;
   logic [RING_AW-1:0]         ptr_ff, ptr_in, ring_raddr;
   logic [WCW-1:0]             done_ff, done_in;
   logic [FRAME_NUMBER_W-1:0]  count_frames_ff, count_frames_in;
   logic [WINDOW_W-1:0]        ring_q, ring_sel;
   logic                       fwd_ff, fwd_in;
   logic [WINDOW_W-1:0]        fwd_data_ff;

   // stage 5
   logic                       v5_ff;
   logic [WINDOW_W-1:0]        cum5_ff, base5_ff;
   logic [MOTION_W-1:0]        motion5_ff;
   logic [FRAME_NUMBER_W-1:0]  number5_ff;

   // result queue
   result_type                 queue_ff [QUEUE_DEPTH];
   result_type                 push_item;
   logic [QUEUE_AW-1:0]        head_ff, head_in, tail_ff, tail_in;
   logic [QUEUE_CW-1:0]        qcount_ff, qcount_in;
   logic                       rsp_pop;
   logic [QUEUE_CW:0]          occupancy;

   // configuration writes and effective values
   always_comb begin
      frame_pixels_in  = frame_pixels_ff;
      window_frames_in = window_frames_ff;
      if (csr_write && csr_index == CSR_FRAME_PIXELS) begin
         frame_pixels_in = csr_data;
      end
      if (csr_write && csr_index == CSR_WINDOW_FRAMES) begin
         window_frames_in = csr_data[WINDOW_FRAMES_W-1:0];
      end
   end

   always_comb begin
      size_eff = SCW'(frame_pixels_ff);
      if (frame_pixels_ff == '0) begin
         size_eff = SCW'(1);
      end else if (SCW'(frame_pixels_ff) > SCW'(MAX_FRAME_PIXELS)) begin
         size_eff = SCW'(MAX_FRAME_PIXELS);
      end
      win_eff = WCW'(window_frames_ff);
      if (window_frames_ff == '0) begin
         win_eff = WCW'(1);
      end else if (WCW'(window_frames_ff) > WCW'(MAX_WINDOW)) begin
         win_eff = WCW'(MAX_WINDOW);
      end
   end

   // accept stage: frame store read and write at the current position
   assign occupancy = (QUEUE_CW + 1)'(qcount_ff) + (QUEUE_CW + 1)'(v1_ff) + (QUEUE_CW + 1)'(v2_ff)
                    + (QUEUE_CW + 1)'(v3_ff) + (QUEUE_CW + 1)'(v4_ff) + (QUEUE_CW + 1)'(v5_ff);
   assign req_stall  = occupancy >= (QUEUE_CW + 1)'(QUEUE_DEPTH);
   assign req_accept = req_valid && !req_stall;
   assign frame_end0 = (SCW'(pos_ff) + SCW'(1)) >= size_eff;

   always_comb begin
      pos_in  = pos_ff;
      fill_in = fill_ff;
      if (req_accept) begin
         pos_in = frame_end0 ? '0 : pos_ff + PIX_AW'(1);
         if ({1'b0, pos_ff} == fill_ff) begin
            fill_in = fill_ff + (PIX_AW + 1)'(1);
         end
      end
   end

   fldm_ram #(
      .WIDTH (PIXEL_W),
      .DEPTH (MAX_FRAME_PIXELS),
      .ADDR_W(PIX_AW)
   ) u_frame_ram (
      .clock  (clock),
      .wr_en  (req_accept),
      .wr_addr(pos_ff),
      .wr_data(req_pixel),
      .rd_addr(pos_ff),
      .rd_data(prev_q)
   );

   // stage 3: accumulate
   assign acc_sum = acc_ff + MOTION_W'(diff3_ff);

   always_comb begin
      acc_in = acc_ff;
      if (v3_ff) begin
         acc_in = end3_ff ? '0 : acc_sum;
      end
   end

   // stage 4: running total, ring of totals
   assign cum_new = cum_ff + WINDOW_W'(motion4_ff);

   always_comb begin
      cum_in          = cum_ff;
      ptr_in          = ptr_ff;
      done_in         = done_ff;
      count_frames_in = count_frames_ff;
      if (v4_ff) begin
         cum_in          = cum_new;
         ptr_in          = (ptr_ff == RING_AW'(MAX_WINDOW - 1)) ? '0 : ptr_ff + RING_AW'(1);
         count_frames_in = count_frames_ff + FRAME_NUMBER_W'(1);
         if (done_ff != WCW'(MAX_WINDOW)) begin
            done_in = done_ff + WCW'(1);
         end
      end
   end

   always_comb begin
      if (WCW'(ptr_in) >= win_eff) begin
         ring_raddr = RING_AW'(WCW'(ptr_in) - win_eff);
      end else begin
         ring_raddr = RING_AW'(WCW'(ptr_in) + (WCW'(MAX_WINDOW) - win_eff));
      end
      fwd_in = v4_ff && (ptr_ff == ring_raddr);
   end

   fldm_ram #(
      .WIDTH (WINDOW_W),
      .DEPTH (MAX_WINDOW),
      .ADDR_W(RING_AW)
   ) u_ring_ram (
      .clock  (clock),
      .wr_en  (v4_ff),
      .wr_addr(ptr_ff),
      .wr_data(cum_new),
      .rd_addr(ring_raddr),
      .rd_data(ring_q)
   );

   always_comb begin
      ring_sel = fwd_ff ? fwd_data_ff : ring_q;
      if (win_eff > done_ff) begin
         ring_sel = '0;
      end
   end

   // stage 5: window sum into the queue
   assign push_item.frame_number  = number5_ff;
   assign push_item.frame_motion  = motion5_ff;
   assign push_item.window_motion = cum5_ff - base5_ff;

   assign rsp_valid         = qcount_ff != '0;
   assign rsp_pop           = rsp_valid && !rsp_stall;
   assign rsp_frame_number  = queue_ff[head_ff].frame_number;
   assign rsp_frame_motion  = queue_ff[head_ff].frame_motion;
   assign rsp_window_motion = queue_ff[head_ff].window_motion;

   always_comb begin
      head_in   = rsp_pop ? head_ff + QUEUE_AW'(1) : head_ff;
      tail_in   = v5_ff ? tail_ff + QUEUE_AW'(1) : tail_ff;
      qcount_in = qcount_ff + QUEUE_CW'(v5_ff) - QUEUE_CW'(rsp_pop);
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         frame_pixels_ff  <= FRAME_PIXELS_RESET;
         window_frames_ff <= WINDOW_FRAMES_RESET;
         pos_ff           <= '0;
         fill_ff          <= '0;
         v1_ff            <= 1'b0;
         v2_ff            <= 1'b0;
         v3_ff            <= 1'b0;
         v4_ff            <= 1'b0;
         v5_ff            <= 1'b0;
         acc_ff           <= '0;
         cum_ff           <= '0;
         ptr_ff           <= '0;
         done_ff          <= '0;
         count_frames_ff  <= '0;
         fwd_ff           <= 1'b0;
         head_ff          <= '0;
         tail_ff          <= '0;
         qcount_ff        <= '0;
      end else begin
         frame_pixels_ff  <= frame_pixels_in;
         window_frames_ff <= window_frames_in;
         pos_ff           <= pos_in;
         fill_ff          <= fill_in;
         v1_ff            <= req_accept;
         v2_ff            <= v1_ff;
         v3_ff            <= v2_ff;
         v4_ff            <= v3_ff && end3_ff;
         v5_ff            <= v4_ff;
         acc_ff           <= acc_in;
         cum_ff           <= cum_in;
         ptr_ff           <= ptr_in;
         done_ff          <= done_in;
         count_frames_ff  <= count_frames_in;
         fwd_ff           <= fwd_in;
         head_ff          <= head_in;
         tail_ff          <= tail_in;
         qcount_ff        <= qcount_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      pix1_ff     <= req_pixel;
      end1_ff     <= frame_end0;
      ok1_ff      <= {1'b0, pos_ff} < fill_ff;
      a2_ff       <= LOG_TABLE[pix1_ff];
      b2_ff       <= LOG_TABLE[ok1_ff ? prev_q : '0];
      end2_ff     <= end1_ff;
      diff3_ff    <= (a2_ff >= b2_ff) ? a2_ff - b2_ff : b2_ff - a2_ff;
      end3_ff     <= end2_ff;
      motion4_ff  <= acc_sum;
      fwd_data_ff <= cum_new;
      cum5_ff     <= cum_new;
      base5_ff    <= ring_sel;
      motion5_ff  <= motion4_ff;
      number5_ff  <= count_frames_ff;
      if (v5_ff) begin
         queue_ff[tail_ff] <= push_item;
      end
   end

endmodule

// ===== design/fldm_checker.sv =====
module fldm_checker
   import fldm_pkg::*;
(
   input logic                      clock,
   input logic                      reset,
   input logic                      req_valid,
   input logic                      req_stall,
   input logic                      rsp_valid,
   input logic                      rsp_stall,
   input logic [FRAME_NUMBER_W-1:0] rsp_frame_number,
   input logic [MOTION_W-1:0]       rsp_frame_motion,
   input logic [WINDOW_W-1:0]       rsp_window_motion
);

   logic [FRAME_NUMBER_W-1:0] expect_number_ff, expect_number_in;
   logic                      req_accept;

   assign req_accept = req_valid && !req_stall;

   always_comb begin
      expect_number_in = expect_number_ff;
      if (rsp_valid && !rsp_stall) begin
         expect_number_in = expect_number_ff + FRAME_NUMBER_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         expect_number_ff <= '0;
      end else begin
         expect_number_ff <= expect_number_in;
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_frame_number)
         && $stable(rsp_frame_motion) && $stable(rsp_window_motion))
      else $error("stalled response changed");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response present after reset");

   a_frame_order: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_frame_number == expect_number_ff)
      else $error("frame number out of sequence");

   a_rsp_cause: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_accept, PIPE_LATENCY))
      else $error("response without a request at the pipeline latency");

endmodule

bind frame_log_difference_motion fldm_checker u_fldm_checker (.*);

// ===== sim/frame_log_difference_motion_tb.sv =====
`timescale 1ns / 100ps

module frame_log_difference_motion_tb;
   import fldm_pkg::*;

   localparam int unsigned CYCLE_LIMIT = 400000;
   localparam int unsigned RANDOM_PIXELS = 600;

   logic                      clock = 1'b0;
   logic                      reset;
   logic                      csr_write;
   logic [CSR_INDEX_W-1:0]    csr_index;
   logic [CSR_DATA_W-1:0]     csr_data;
   logic                      req_valid;
   logic                      req_stall;
   logic [PIXEL_W-1:0]        req_pixel;
   logic                      rsp_valid;
   logic                      rsp_stall;
   logic [FRAME_NUMBER_W-1:0] rsp_frame_number;
   logic [MOTION_W-1:0]       rsp_frame_motion;
   logic [WINDOW_W-1:0]       rsp_window_motion;

   frame_log_difference_motion DUT (
      .clock             (clock),
      .reset             (reset),
      .csr_write         (csr_write),
      .csr_index         (csr_index),
      .csr_data          (csr_data),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_pixel         (req_pixel),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_frame_number  (rsp_frame_number),
      .rsp_frame_motion  (rsp_frame_motion),
      .rsp_window_motion (rsp_window_motion)
   );

   always #5 clock = ~clock;

   // motion predictor state
   logic [LOG_W-1:0]           ln_lut [0:LOG_ENTRIES-1];
   bit   [PIXEL_W-1:0]         prev_frame [0:MAX_FRAME_PIXELS_DEFAULT-1];
   bit   [MOTION_W-1:0]        motion_ring [0:MAX_WINDOW_DEFAULT-1];
   int unsigned                ring_slot = 0;
   int unsigned                frame_position = 0;
   logic [MOTION_W-1:0]        frame_sum = '0;
   logic [FRAME_NUMBER_W-1:0]  frame_count = '0;
   logic [FRAME_PIXELS_W-1:0]  size_setting = FRAME_PIXELS_RESET;
   logic [WINDOW_FRAMES_W-1:0] window_setting = WINDOW_FRAMES_RESET;

   result_type  reports_due [$];
   int unsigned faults = 0;
   int unsigned cycle_count = 0;
   bit          quiet = 1'b0;

   function automatic int unsigned pause_len();
      int unsigned r;
      if (quiet) return 0;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic void accumulate_motion(input logic [PIXEL_W-1:0] px);
      int unsigned         size;
      int unsigned         win;
      int unsigned         pos;
      int unsigned         k;
      logic [LOG_W-1:0]    now_ln;
      logic [LOG_W-1:0]    old_ln;
      logic [WINDOW_W-1:0] total;
      result_type          rep;
      size = size_setting;
      if (size == 0) size = 1;
      if (size > MAX_FRAME_PIXELS_DEFAULT) size = MAX_FRAME_PIXELS_DEFAULT;
      win = window_setting;
      if (win == 0) win = 1;
      if (win > MAX_WINDOW_DEFAULT) win = MAX_WINDOW_DEFAULT;
      pos = frame_position;
      now_ln = ln_lut[px];
      old_ln = ln_lut[prev_frame[pos]];
      if (now_ln >= old_ln) frame_sum = frame_sum + MOTION_W'(now_ln - old_ln);
      else frame_sum = frame_sum + MOTION_W'(old_ln - now_ln);
      prev_frame[pos] = px;
      if (pos + 1 < size) begin
         frame_position = pos + 1;
         return;
      end
      motion_ring[ring_slot] = frame_sum;
      total = '0;
      for (k = 0; k < win; k++) begin
         total = total + WINDOW_W'(motion_ring[(ring_slot + MAX_WINDOW_DEFAULT - k)
                                               % MAX_WINDOW_DEFAULT]);
      end
      rep.frame_number = frame_count;
      rep.frame_motion = frame_sum;
      rep.window_motion = total;
      reports_due.push_back(rep);
      ring_slot = (ring_slot + 1) % MAX_WINDOW_DEFAULT;
      frame_count = frame_count + 1;
      frame_sum = '0;
      frame_position = 0;
   endfunction

   task automatic send_pixel(input logic [PIXEL_W-1:0] px);
      int unsigned idle;
      idle = pause_len();
      if (idle != 0) begin
         req_valid <= 1'b0;
         repeat (idle) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_pixel <= px;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      accumulate_motion(px);
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      while (reports_due.size() != 0) @(posedge clock);
      repeat (PIPE_LATENCY + 4) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_INDEX_W-1:0] index,
                            input logic [CSR_DATA_W-1:0] data);
      csr_write <= 1'b1;
      csr_index <= index;
      csr_data  <= data;
      if (index == CSR_FRAME_PIXELS) size_setting = data[FRAME_PIXELS_W-1:0];
      else window_setting = data[WINDOW_FRAMES_W-1:0];
      @(posedge clock);
      csr_write <= 1'b0;
      @(posedge clock);
   endtask

   // default frame size: no report may appear, then shrinking the frame ends it
   task automatic test_default_frame_size();
      send_pixel(8'd0);
      send_pixel(8'd255);
      send_pixel(8'd1);
      send_pixel(8'd128);
      send_pixel(8'd254);
      send_pixel(8'd255);
      settle();
      write_csr(CSR_FRAME_PIXELS, CSR_DATA_W'(1));
      send_pixel(8'd77);
      settle();
   endtask

   // zero and oversized settings, and a frame cut short from the largest size
   task automatic test_clamped_settings();
      write_csr(CSR_FRAME_PIXELS, '0);
      write_csr(CSR_WINDOW_FRAMES, '0);
      send_pixel(8'd255);
      send_pixel(8'd0);
      settle();
      write_csr(CSR_WINDOW_FRAMES, CSR_DATA_W'(127));
      send_pixel(8'd255);
      send_pixel(8'd255);
      send_pixel(8'd0);
      settle();
      write_csr(CSR_FRAME_PIXELS, {CSR_DATA_W{1'b1}});
      send_pixel(8'd255);
      send_pixel(8'd170);
      send_pixel(8'd85);
      send_pixel(8'd0);
      settle();
      write_csr(CSR_FRAME_PIXELS, CSR_DATA_W'(3));
      send_pixel(8'd200);
      settle();
   endtask

   task automatic test_random_frames();
      int unsigned sent;
      int unsigned pick;
      int unsigned eff;
      int unsigned frames;
      int unsigned n;
      int unsigned i;
      int unsigned mode;
      logic [PIXEL_W-1:0] px;
      sent = 0;
      mode = 0;
      while (sent < RANDOM_PIXELS) begin
         settle();
         quiet = ($urandom_range(0, 5) == 0);
         if ($urandom_range(0, 3) != 0) begin
            pick = $urandom_range(0, 19);
            if (pick == 0) eff = 0;
            else if (pick < 12) eff = $urandom_range(1, 12);
            else if (pick < 18) eff = $urandom_range(13, 48);
            else eff = $urandom_range(49, 100);
            write_csr(CSR_FRAME_PIXELS, CSR_DATA_W'(eff));
         end
         if ($urandom_range(0, 2) != 0) begin
            pick = $urandom_range(0, 9);
            if (pick == 0) eff = 0;
            else if (pick == 1) eff = 1;
            else if (pick == 2) eff = MAX_WINDOW_DEFAULT;
            else if (pick == 3) eff = $urandom_range(MAX_WINDOW_DEFAULT + 1, 127);
            else eff = $urandom_range(2, MAX_WINDOW_DEFAULT - 1);
            write_csr(CSR_WINDOW_FRAMES, CSR_DATA_W'(eff));
         end
         eff = (size_setting == 0) ? 1 : size_setting;
         frames = (eff > 48) ? $urandom_range(1, 2) : $urandom_range(1, 4);
         n = frames * eff;
         if ($urandom_range(0, 3) == 0) n = n + $urandom_range(1, eff);
         for (i = 0; i < n; i++) begin
            if (i == 0 || frame_position == 0) mode = $urandom_range(0, 3);
            case (mode)
               0: px = PIXEL_W'($urandom_range(0, 255));
               1: px = prev_frame[frame_position];
               2: px = ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
               default: px = prev_frame[frame_position] + PIXEL_W'($urandom_range(0, 6))
                             - PIXEL_W'(3);
            endcase
            send_pixel(px);
            sent++;
         end
      end
      quiet = 1'b0;
   endtask

   initial begin
      int unsigned i;
      reset = 1'b1;
      csr_write = 1'b0;
      csr_index = '0;
      csr_data = '0;
      req_valid = 1'b0;
      req_pixel = '0;
      for (i = 0; i < LOG_ENTRIES; i++) begin
         ln_lut[i] = LOG_W'($rtoi($floor($ln(real'(i + 1)) * (2.0 ** LOG_FRACTION_BITS)
                                         + 0.5)));
      end
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      test_default_frame_size();
      test_clamped_settings();
      test_random_frames();
      settle();
      if (faults == 0 && reports_due.size() == 0) begin
         $display("frame_log_difference_motion_tb: clean");
      end else begin
         $display("frame_log_difference_motion_tb: errors");
      end
      $finish;
   end

   // result side back-pressure
   initial begin : rsp_pacing
      int unsigned held;
      rsp_stall = 1'b0;
      forever begin
         rsp_stall <= 1'b0;
         repeat (1 + pause_len()) @(posedge clock);
         held = pause_len();
         if (held != 0) begin
            rsp_stall <= 1'b1;
            repeat (held) @(posedge clock);
         end
      end
   end

   always @(posedge clock) begin : report_check
      result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (reports_due.size() == 0) begin
            $error("unexpected frame report: frame_number %0d", rsp_frame_number);
            faults++;
         end else begin
            want = reports_due.pop_front();
            if (want.frame_number !== rsp_frame_number) begin
               $error("frame_number: expected %0d, got %0d", want.frame_number,
                      rsp_frame_number);
               faults++;
            end
            if (want.frame_motion !== rsp_frame_motion) begin
               $error("frame_motion: expected %0d, got %0d", want.frame_motion,
                      rsp_frame_motion);
               faults++;
            end
            if (want.window_motion !== rsp_window_motion) begin
               $error("window_motion: expected %0d, got %0d", want.window_motion,
                      rsp_window_motion);
               faults++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("frame_log_difference_motion_tb: errors");
         $finish;
      end
   end

endmodule

// ===== sim.f =====
design/fldm_pkg.sv
design/fldm_ram.sv
design/frame_log_difference_motion.sv
design/fldm_checker.sv
sim/frame_log_difference_motion_tb.sv
